FILE: rtl/core/stable_sorted_priority_queue_core_macros.svh
// assertion macros for the sorted priority queue checker
`ifndef STABLE_SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH
`define STABLE_SORTED_PRIORITY_QUEUE_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SSPQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SSPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/sspq_pkg.sv
// shared types and codes of the sorted priority queue
`default_nettype none

package sspq_pkg;

  localparam int ID_W     = 16;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 5;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/sspq_if.sv
// request and response channel interfaces
`default_nettype none

interface sspq_req_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [sspq_pkg::ID_W-1:0]   entry_id;
  logic [sspq_pkg::PRIO_W-1:0] entry_priority;

  modport source (output valid, op, entry_id, entry_priority, input ready);
  modport sink   (input valid, op, entry_id, entry_priority, output ready);
endinterface

interface sspq_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [sspq_pkg::ID_W-1:0]     out_id;
  logic [sspq_pkg::PRIO_W-1:0]   out_priority;
  logic [sspq_pkg::STATUS_W-1:0] status;
  logic [sspq_pkg::OCC_W-1:0]    occupancy;

  modport source (output valid, out_id, out_priority, status, occupancy, input ready);
  modport sink   (input valid, out_id, out_priority, status, occupancy, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/sspq_ctrl.sv
// controller state machine of the sorted priority queue
`default_nettype none

module sspq_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              req_valid,
  output logic             req_ready,
  output logic             rsp_valid,
  input  wire              rsp_ready,
  output sspq_pkg::cmd_t   cmd
);
  import sspq_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid || rsp_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    req_ready   = 1'b0;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    unique case (state)
      S_IDLE: begin
        req_ready   = 1'b1;
        cmd.capture = req_valid;
      end
      S_EXEC: begin
        cmd.execute = !out_valid || rsp_ready;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.execute) begin
      out_valid_next = 1'b1;
    end else if (rsp_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign rsp_valid = out_valid;

endmodule

`default_nettype wire

FILE: rtl/core/sspq_dpath.sv
// datapath of the sorted priority queue: slot cells, count and result register
`default_nettype none

module sspq_dpath #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8,
  parameter int ID_BITS   = 16
) (
  input  wire                                clk,
  input  wire                                rst,
  input  sspq_pkg::cmd_t                     cmd,
  input  wire                                req_op,
  input  wire [sspq_pkg::ID_W-1:0]           req_id,
  input  wire [sspq_pkg::PRIO_W-1:0]         req_prio,
  output logic [sspq_pkg::ID_W-1:0]          rsp_id,
  output logic [sspq_pkg::PRIO_W-1:0]        rsp_prio,
  output logic [sspq_pkg::STATUS_W-1:0]      rsp_status,
  output logic [sspq_pkg::OCC_W-1:0]         rsp_occ
);
  import sspq_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                 item_op;
  logic [ID_BITS-1:0]   item_id;
  logic [PRIO_BITS-1:0] item_prio;

  logic [ID_BITS-1:0]   slot_id   [DEPTH];
  logic [PRIO_BITS-1:0] slot_prio [DEPTH];
  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;

  logic [DEPTH-1:0]     keep;
  logic                 empty;
  logic                 full;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(DEPTH));

  // cells holding an entry of priority at least the new one stay in place
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < count) && (slot_prio[i] >= item_prio);
    end
  end

  always_comb begin
    count_next = count;
    if (item_op == OP_DEQ) begin
      if (!empty) count_next = count - CNT_W'(1);
    end else if (!full) begin
      count_next = count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_op   <= req_op;
      item_id   <= ID_BITS'(req_id);
      item_prio <= PRIO_BITS'(req_prio);
    end
  end

  // compare-and-shift cells
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      if (item_op == OP_DEQ) begin
        if (!empty) begin
          for (int i = 0; i < DEPTH - 1; i++) begin
            slot_id[i]   <= slot_id[i+1];
            slot_prio[i] <= slot_prio[i+1];
          end
        end
      end else if (!full) begin
        if (!keep[0]) begin
          slot_id[0]   <= item_id;
          slot_prio[0] <= item_prio;
        end
        for (int i = 1; i < DEPTH; i++) begin
          if (!keep[i]) begin
            if (keep[i-1]) begin
              slot_id[i]   <= item_id;
              slot_prio[i] <= item_prio;
            end else begin
              slot_id[i]   <= slot_id[i-1];
              slot_prio[i] <= slot_prio[i-1];
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsp_occ <= OCC_W'(count_next);
      if (item_op == OP_DEQ && !empty) begin
        rsp_id   <= ID_W'(slot_id[0]);
        rsp_prio <= PRIO_W'(slot_prio[0]);
      end else begin
        rsp_id   <= '0;
        rsp_prio <= '0;
      end
      if (item_op == OP_DEQ && empty) begin
        rsp_status <= ST_EMPTY;
      end else if (item_op == OP_ENQ && full) begin
        rsp_status <= ST_FULL;
      end else begin
        rsp_status <= ST_OK;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/stable_sorted_priority_queue_core.sv
// top level of the stable sorted priority queue
// usage:
//   req channel carries one operation per transaction: op selects enqueue or
//   dequeue, entry_id and entry_priority give the entry to enqueue
//   rsp channel returns exactly one transaction per request: the dequeued
//   entry (zero otherwise), a status code and the occupancy after the request
//   entries leave in descending priority, equal priorities in arrival order
//   a dequeue on an empty queue reports empty status, an enqueue on a full
//   queue is dropped and reports full status
// timing:
//   a request is registered at acceptance, applied to the slot cells once
//   the response register is free, and its response is valid the cycle after
//   each request is captured and then executed by the controller before the
//   next is taken; all DEPTH cells compare and shift together in execute
//   the next request is taken while a response waits; execution then holds
//   until the response register is free, so a stalled receiver backs up req
// reset:
//   synchronous rst empties the queue and drops any pending response
//   slot contents are not cleared, only the entry count
`default_nettype none

module stable_sorted_priority_queue_core #(
  parameter int DEPTH     = 16,
  parameter int PRIO_BITS = 8,
  parameter int ID_BITS   = 16
) (
  input  wire        clk,
  input  wire        rst,
  sspq_req_if.sink   req,
  sspq_rsp_if.source rsp
);
  import sspq_pkg::*;

  cmd_t cmd;

  // controller: handshakes and sequencing
  sspq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  // datapath: item register, sorted slot cells, count and response register
  sspq_dpath #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS),
    .ID_BITS   (ID_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .req_op     (req.op),
    .req_id     (req.entry_id),
    .req_prio   (req.entry_priority),
    .rsp_id     (rsp.out_id),
    .rsp_prio   (rsp.out_priority),
    .rsp_status (rsp.status),
    .rsp_occ    (rsp.occupancy)
  );

endmodule

`default_nettype wire

FILE: rtl/core/sspq_checker.sv
// port-level assertions for the sorted priority queue and their bind
`default_nettype none
`include "stable_sorted_priority_queue_core_macros.svh"

module sspq_checker (
  input wire                                clk,
  input wire                                rst,
  input wire                                rsp_valid,
  input wire                                rsp_ready,
  input wire [sspq_pkg::ID_W-1:0]           rsp_id,
  input wire [sspq_pkg::PRIO_W-1:0]         rsp_prio,
  input wire [sspq_pkg::STATUS_W-1:0]       rsp_status,
  input wire [sspq_pkg::OCC_W-1:0]          rsp_occ
);
  import sspq_pkg::*;

  `SSPQ_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
  `SSPQ_ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(rsp_id) && $stable(rsp_prio) && $stable(rsp_status) && $stable(rsp_occ), "response changed while stalled")
  `SSPQ_ASSERT_NOW(a_err_zero, clk, rst, rsp_valid && rsp_status != ST_OK, rsp_id == '0 && rsp_prio == '0, "error response carries an entry")
  `SSPQ_ASSERT_NOW(a_empty_occ, clk, rst, rsp_valid && rsp_status == ST_EMPTY, rsp_occ == '0, "empty status with nonzero occupancy")

endmodule

bind stable_sorted_priority_queue_core sspq_checker u_sspq_checker (
  .clk        (clk),
  .rst        (rst),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_id     (rsp.out_id),
  .rsp_prio   (rsp.out_priority),
  .rsp_status (rsp.status),
  .rsp_occ    (rsp.occupancy)
);

`default_nettype wire
